@@ sv/skyatl_pkg.sv @@
// Shared types, constants and helpers for the skyline atlas allocator.
`default_nettype none
package skyatl_pkg;

  localparam int DEF_MAX_SIDE = 4096;   // default atlas column count
  localparam int DIM_W        = 13;     // rect dims, side register, column heights
  localparam int XY_W         = 12;     // place_x / place_y
  localparam int NUM_W        = 16;     // atlas_number
  localparam int CNT_W        = 17;     // internal atlas counter
  localparam int IN_DATA_W    = 32;     // two 13-bit dims, padded to bytes
  localparam int OUT_DATA_W   = 40;     // x, y, atlas number
  localparam int OUT_USER_W   = 2;      // started_new, status

  localparam logic [DIM_W-1:0] SIDE_RESET = 13'd4096;
  localparam logic [CNT_W-1:0] CNT_MAX    = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,     // forward pass: block prefix maxima into scratch RAM
    ST_BWD,     // backward pass: suffix maxima, window max, best pick
    ST_DECIDE,
    ST_WRITE,   // raise covered columns
    ST_FRESH,   // new atlas: sweep every column
    ST_DONE
  } st_t;

  function automatic logic [DIM_W-1:0] hmax(input logic [DIM_W-1:0] a,
                                            input logic [DIM_W-1:0] b);
    hmax = (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

@@ sv/skyline_atlas_allocator_top.sv @@
// Skyline bottom-left rectangle allocator for a square atlas: top level.
//
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  word: rect_width, rect_height
//  m_axis    out  m_axis_tvalid/m_axis_tready  word: place_x, place_y, atlas_number
//                                              + tuser: started_new, status
//  cfg       in   cfg_wen (no wait)            atlas_side
//
//  Each pass moves one column per cycle through the one-read, one-write memory.
//  rst (sync, active high) clears control state and the atlas counter; the
//  column memory is not cleared, since the first placed word always sweeps it.
//  s_axis_tready is high only in idle; a finished result waits in the output
//  register, and a new word may be taken while it waits.
`default_nettype none
module skyline_atlas_allocator_top #(
  parameter int MAX_SIDE = skyatl_pkg::DEF_MAX_SIDE
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // cfg: atlas_side
  input  wire logic                              cfg_wen,
  input  wire logic [skyatl_pkg::DIM_W-1:0]      cfg_wdata,
  // tdata: [12:0] rect_width, [25:13] rect_height, [31:26] zero
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [skyatl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tdata: [11:0] place_x, [23:12] place_y, [39:24] atlas_number
  // tuser: [0] started_new, [1] status
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [skyatl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [skyatl_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
  import skyatl_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);       // column address
  localparam int KW = $clog2(MAX_SIDE + 1);   // counters, can hold the side itself

  // config register
  logic [DIM_W-1:0] atlas_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_side <= SIDE_RESET;
    end else if (cfg_wen) begin
      atlas_side <= cfg_wdata;
    end
  end

  // effective side: zero acts as 1, clamp to MAX_SIDE
  logic [DIM_W-1:0] eff_side;
  always_comb begin
    if (atlas_side == '0) begin
      eff_side = DIM_W'(1);
    end else if (32'(atlas_side) > MAX_SIDE) begin
      eff_side = DIM_W'(MAX_SIDE);
    end else begin
      eff_side = atlas_side;
    end
  end

  // incoming fields
  logic [DIM_W-1:0] in_w, in_h;
  logic             in_bad;
  assign in_w   = s_axis_tdata[DIM_W-1:0];
  assign in_h   = s_axis_tdata[2*DIM_W-1:DIM_W];
  assign in_bad = (in_w == '0) || (in_h == '0) || (in_w > eff_side) || (in_h > eff_side);

  // sequencer state
  st_t              state, state_next;
  logic [KW-1:0]    cnt, cnt_next;        // pass counter
  logic [KW-1:0]    pos, pos_next;        // offset within a block of w columns
  logic             rd_vld, rd_vld_next;  // read data arrives this cycle
  logic [KW-1:0]    rd_idx, rd_idx_next;  // column of that read data
  logic [DIM_W-1:0] w_r, w_next, h_r, h_next, side_r, side_next;
  logic [DIM_W-1:0] acc, acc_next;        // running prefix / suffix max
  logic [DIM_W-1:0] best, best_next;
  logic [KW-1:0]    best_x, best_x_next;
  logic [KW-1:0]    px, px_next;
  logic [DIM_W-1:0] py, py_next;
  logic             fresh, fresh_next;
  logic             rej, rej_next;
  logic [CNT_W-1:0] atlas_count, atlas_count_next;

  // output register
  logic                  out_load;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_USER_W-1:0] out_user;

  // memory ports
  logic             h_we, g_we;
  logic [AW-1:0]    h_waddr, h_raddr, g_waddr, g_raddr;
  logic [DIM_W-1:0] h_wdata, g_wdata, h_rdata, g_rdata;

  skyatl_ram #(.DEPTH(MAX_SIDE), .DW(DIM_W)) u_heights (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // per-column prefix max within each block, filled by the forward pass
  skyatl_ram #(.DEPTH(MAX_SIDE), .DW(DIM_W)) u_prefix (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  logic [KW-1:0]    side_k, w_k;
  logic [KW-1:0]    bwd_addr;
  logic [DIM_W-1:0] pre_v, suf_v, win_max;
  logic             blk_end, win_ok;

  assign side_k   = KW'(side_r);
  assign w_k      = KW'(w_r);
  assign bwd_addr = side_k - KW'(1) - cnt;
  assign pre_v    = (pos == '0) ? h_rdata : hmax(acc, h_rdata);
  assign blk_end  = (pos == w_k - KW'(1)) || (rd_idx == side_k - KW'(1));
  assign suf_v    = blk_end ? h_rdata : hmax(acc, h_rdata);
  assign win_max  = hmax(suf_v, g_rdata);
  assign win_ok   = ({1'b0, rd_idx} + {1'b0, w_k}) <= {1'b0, side_k};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_vld      <= 1'b0;
      atlas_count <= '0;
    end else begin
      state       <= state_next;
      rd_vld      <= rd_vld_next;
      atlas_count <= atlas_count_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    pos    <= pos_next;
    rd_idx <= rd_idx_next;
    w_r    <= w_next;
    h_r    <= h_next;
    side_r <= side_next;
    acc    <= acc_next;
    best   <= best_next;
    best_x <= best_x_next;
    px     <= px_next;
    py     <= py_next;
    fresh  <= fresh_next;
    rej    <= rej_next;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pos_next         = pos;
    rd_vld_next      = 1'b0;
    rd_idx_next      = rd_idx;
    w_next           = w_r;
    h_next           = h_r;
    side_next        = side_r;
    acc_next         = acc;
    best_next        = best;
    best_x_next      = best_x;
    px_next          = px;
    py_next          = py;
    fresh_next       = fresh;
    rej_next         = rej;
    atlas_count_next = atlas_count;
    s_axis_tready    = 1'b0;
    out_load         = 1'b0;
    h_we             = 1'b0;
    h_waddr          = '0;
    h_wdata          = '0;
    h_raddr          = '0;
    g_we             = 1'b0;
    g_waddr          = '0;
    g_wdata          = '0;
    g_raddr          = '0;

    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          w_next      = in_w;
          h_next      = in_h;
          side_next   = eff_side;
          best_next   = eff_side;
          best_x_next = '0;
          fresh_next  = 1'b0;
          cnt_next    = '0;
          pos_next    = '0;
          rej_next    = in_bad;
          if (in_bad) begin
            state_next = ST_DONE;
          end else if (atlas_count == '0) begin
            // best still equals side, so DECIDE opens the first atlas
            state_next = ST_DECIDE;
          end else begin
            state_next = ST_FWD;
          end
        end
      end

      ST_FWD: begin
        if (cnt < side_k) begin
          h_raddr     = AW'(cnt);
          rd_vld_next = 1'b1;
          rd_idx_next = cnt;
          cnt_next    = cnt + KW'(1);
        end
        if (rd_vld) begin
          g_we     = 1'b1;
          g_waddr  = AW'(rd_idx);
          g_wdata  = pre_v;
          acc_next = pre_v;
          pos_next = (pos == w_k - KW'(1)) ? '0 : pos + KW'(1);
        end else if (cnt == side_k) begin
          // pos now belongs to column side; step back to side-1
          state_next = ST_BWD;
          cnt_next   = '0;
          pos_next   = (pos == '0) ? w_k - KW'(1) : pos - KW'(1);
        end
      end

      ST_BWD: begin
        if (cnt < side_k) begin
          h_raddr     = AW'(bwd_addr);
          g_raddr     = AW'(bwd_addr + w_k - KW'(1));
          rd_vld_next = 1'b1;
          rd_idx_next = bwd_addr;
          cnt_next    = cnt + KW'(1);
        end
        if (rd_vld) begin
          acc_next = suf_v;
          pos_next = (pos == '0) ? w_k - KW'(1) : pos - KW'(1);
          // scanning leftward, ties move to the lower column
          if (win_ok && (win_max <= best) && (win_max < side_r)) begin
            best_next   = win_max;
            best_x_next = rd_idx;
          end
        end else if (cnt == side_k) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        cnt_next = '0;
        if (({1'b0, best} + {1'b0, h_r}) <= {1'b0, side_r}) begin
          px_next    = best_x;
          py_next    = best;
          state_next = ST_WRITE;
        end else begin
          px_next    = '0;
          py_next    = '0;
          fresh_next = 1'b1;
          if (atlas_count != CNT_MAX) begin
            atlas_count_next = atlas_count + CNT_W'(1);
          end
          state_next = ST_FRESH;
        end
      end

      ST_WRITE: begin
        h_we     = 1'b1;
        h_waddr  = AW'(px + cnt);
        h_wdata  = py + h_r;
        cnt_next = cnt + KW'(1);
        if (cnt == w_k - KW'(1)) begin
          state_next = ST_DONE;
        end
      end

      ST_FRESH: begin
        // clear every column, raising the first w to h
        h_we     = 1'b1;
        h_waddr  = AW'(cnt);
        h_wdata  = (cnt < w_k) ? h_r : '0;
        cnt_next = cnt + KW'(1);
        if (cnt == KW'(MAX_SIDE - 1)) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result word
  logic [NUM_W-1:0] atlas_idx;
  assign atlas_idx = NUM_W'(atlas_count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rej) begin
        out_data <= '0;
        out_user <= OUT_USER_W'(2);   // status set, started_new clear
      end else begin
        out_data <= {atlas_idx, py[XY_W-1:0], XY_W'(px)};
        out_user <= {1'b0, fresh};
      end
    end
  end

  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_user;

endmodule
`default_nettype wire

@@ sv/skyatl_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module skyatl_ram #(
  parameter int DEPTH = skyatl_pkg::DEF_MAX_SIDE,
  parameter int DW    = skyatl_pkg::DIM_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the skyline atlas allocator: directed table, then random phases.
`timescale 1ns / 100ps
module tb_top;
  import skyatl_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int MAX_SIDE        = DEF_MAX_SIDE;
  localparam int LONG_GAP_MAX    = 150;
  localparam int HOLD_OFF_CYCLES = 6000;   // one long sink stall, enough to back the block up
  localparam int END_SETTLE      = 64;     // quiet cycles after the last word came back
  // Slowest word: overflow scan at full side plus both sides' longest gaps.
  localparam int WORD_BUDGET     = 3 * MAX_SIDE + 2 * LONG_GAP_MAX + 32;
  localparam int CYCLE_LIMIT     = 4 * 200 * WORD_BUDGET + HOLD_OFF_CYCLES;
  localparam int KEEP_SIDE       = -1;     // table row that leaves the side register alone
  localparam int DIM_MAX         = (1 << DIM_W) - 1;

  localparam logic STAT_PLACED   = 1'b0;
  localparam logic STAT_REJECTED = 1'b1;

  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [NUM_W-1:0] atlas;
    logic             fresh;
    logic             status;
  } placement_t;

  // One directed word; want is used only when typed is set.
  typedef struct {
    int         side;
    int         w;
    int         h;
    bit         typed;
    placement_t want;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wen;
  logic [DIM_W-1:0]      cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // Shadow of the block: per-column skyline, atlas counter, side register.
  logic [DIM_W-1:0] skyline [0:MAX_SIDE-1];
  logic [CNT_W-1:0] atlas_total;
  logic [DIM_W-1:0] side_cfg;

  placement_t placements_due[$];
  probe_t     probes[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  bit         idle_on     = 1'b1;   // random gaps on both sides
  bit         hold_off_req = 1'b0;  // asks the sink for one long stall

  always #(CLK_PERIOD / 2) clk = ~clk;

  skyline_atlas_allocator_top #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [12:0] rect_width, [25:13] rect_height
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [11:0] place_x, [23:12] place_y, [39:24] atlas_number
    .m_axis_tuser  (m_axis_tuser)     // [0] started_new, [1] status
  );

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow allocator
  // ---------------------------------------------------------------------------
  // Side as the block uses it: zero acts as 1, anything past MAX_SIDE clamps.
  function automatic int eff_side();
    if (side_cfg == '0) return 1;
    if (side_cfg > MAX_SIDE) return MAX_SIDE;
    return int'(side_cfg);
  endfunction

  // Bottom-left pick over the first side columns; updates the shadow state.
  task automatic place_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            output placement_t res);
    int side, wi, hi, best, best_x, x, y, i;
    int win[$];   // column indexes, heights strictly falling front to back
    side = eff_side();
    wi   = int'(w);
    hi   = int'(h);
    res  = '0;
    if (wi == 0 || hi == 0 || wi > side || hi > side) begin
      res.status = STAT_REJECTED;
      return;
    end
    best   = side;   // a column at or above the side can never win
    best_x = 0;
    if (atlas_total != '0) begin
      for (i = 0; i < side; i++) begin
        while (win.size() > 0 && skyline[win[$]] <= skyline[i])
          void'(win.pop_back());
        win.push_back(i);
        if (win[0] + wi <= i)
          void'(win.pop_front());
        // strict less-than keeps the leftmost of equal windows
        if (i + 1 >= wi && int'(skyline[win[0]]) < best) begin
          best   = int'(skyline[win[0]]);
          best_x = i + 1 - wi;
        end
      end
    end
    if (best + hi <= side) begin
      x = best_x;
      y = best;
    end else begin
      // new atlas: counter saturates, columns cleared anyway
      if (atlas_total < CNT_MAX)
        atlas_total++;
      foreach (skyline[k])
        skyline[k] = '0;
      x = 0;
      y = 0;
      res.fresh = 1'b1;
    end
    for (i = 0; i < wi; i++)
      skyline[(x + i) & (MAX_SIDE - 1)] = DIM_W'(y + hi);
    res.x      = XY_W'(x);
    res.y      = XY_W'(y);
    res.atlas  = NUM_W'(atlas_total - CNT_W'(1));
    res.status = STAT_PLACED;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_field(string name, int got_v, int want_v);
    if (got_v != want_v) begin
      mismatches++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", name, got_v, want_v,
               cycle_count);
    end
  endtask

  always @(posedge clk) begin : result_check
    placement_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x      = m_axis_tdata[XY_W-1:0];
      got.y      = m_axis_tdata[2*XY_W-1:XY_W];
      got.atlas  = m_axis_tdata[2*XY_W+NUM_W-1:2*XY_W];
      got.fresh  = m_axis_tuser[0];
      got.status = m_axis_tuser[1];
      if (placements_due.size() == 0) begin
        report_field("unexpected word, status", int'(got.status), -1);
      end else begin
        want = placements_due.pop_front();
        report_field("place_x", int'(got.x), int'(want.x));
        report_field("place_y", int'(got.y), int'(want.y));
        report_field("atlas_number", int'(got.atlas), int'(want.atlas));
        report_field("started_new", int'(got.fresh), int'(want.fresh));
        report_field("status", int'(got.status), int'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random ready gaps, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(20, LONG_GAP_MAX);
    return $urandom_range(1, 3);
  endfunction

  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // Offer one word, wait for the handshake, then log what should come back.
  task automatic offer_word(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input bit typed, input placement_t want);
    placement_t res;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 2 * DIM_W){1'b0}}, h, w};
    do @(posedge clk); while (!s_axis_tready);
    place_rect(w, h, res);
    placements_due.push_back(typed ? want : res);
  endtask

  task automatic source_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = pick_gap();
      repeat (n) @(negedge clk) s_axis_tvalid <= 1'b0;
    end
  endtask

  // Drop valid and let every outstanding word come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_side(input int v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v[DIM_W-1:0];
    @(posedge clk);
    side_cfg = v[DIM_W-1:0];
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic plan(input int side, input int w, input int h, input bit typed = 1'b0,
                      input int x = 0, input int y = 0, input int atlas = 0,
                      input bit fresh = 1'b0, input bit status = STAT_PLACED);
    probe_t p;
    p.side         = side;
    p.w            = w;
    p.h            = h;
    p.typed        = typed;
    p.want.x       = XY_W'(x);
    p.want.y       = XY_W'(y);
    p.want.atlas   = NUM_W'(atlas);
    p.want.fresh   = fresh;
    p.want.status  = status;
    probes.push_back(p);
  endtask

  // Random request: mostly well-formed, many small so atlases hold several
  // rects, the rest zero or oversize noise across all 13 bits.
  task automatic pick_rect(output logic [DIM_W-1:0] w, output logic [DIM_W-1:0] h);
    int side, lim, r;
    side = eff_side();
    lim  = (side / 4 > 1) ? side / 4 : 1;
    r    = $urandom_range(0, 99);
    if (r < 8) begin
      w = DIM_W'($urandom_range(0, DIM_MAX));
      h = DIM_W'($urandom_range(0, DIM_MAX));
    end else if (r < 14) begin
      w = ($urandom_range(0, 1) == 0) ? '0 : DIM_W'($urandom_range(1, side));
      h = (w == 0) ? DIM_W'($urandom_range(0, side)) : '0;
    end else if (r < 60) begin
      w = DIM_W'($urandom_range(1, lim));
      h = DIM_W'($urandom_range(1, lim));
    end else begin
      w = DIM_W'($urandom_range(1, side));
      h = DIM_W'($urandom_range(1, side));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  // Random phases: side setting and word count. Big sides get few words since
  // every scan there covers thousands of columns.
  int phase_side [10] = '{16, 8, 64, 1, 33, 4096, 128, 8191, 20, 2};
  int phase_len  [10] = '{18, 12, 16, 8, 14, 4, 14, 4, 16, 13};

  initial begin : stimulus
    logic [DIM_W-1:0] w, h;
    placement_t       none;
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    none          = '0;
    side_cfg      = SIDE_RESET;
    atlas_total   = '0;
    foreach (skyline[k])
      skyline[k] = '0;

    // Directed table, reset side 4096 to start.
    // Bad dimensions: zero, all ones, one past the side.
    plan(KEEP_SIDE, 0, 5, 1, 0, 0, 0, 0, STAT_REJECTED);
    plan(KEEP_SIDE, 5, 0, 1, 0, 0, 0, 0, STAT_REJECTED);
    plan(KEEP_SIDE, DIM_MAX, DIM_MAX, 1, 0, 0, 0, 0, STAT_REJECTED);
    plan(KEEP_SIDE, MAX_SIDE + 1, 1, 1, 0, 0, 0, 0, STAT_REJECTED);
    // First word always opens atlas 0; a full-side square overflows into atlas 1.
    plan(KEEP_SIDE, 1, 1, 1, 0, 0, 0, 1);
    plan(KEEP_SIDE, MAX_SIDE, MAX_SIDE, 1, 0, 0, 1, 1);
    // Smallest side: every word opens an atlas; width 2 no longer fits.
    plan(1, 1, 1, 1, 0, 0, 2, 1);
    plan(KEEP_SIDE, 1, 1, 1, 0, 0, 3, 1);
    plan(KEEP_SIDE, 2, 1, 1, 0, 0, 0, 0, STAT_REJECTED);
    // Side zero behaves as side 1.
    plan(0, 1, 1, 1, 0, 0, 4, 1);
    plan(KEEP_SIDE, 1, 2, 1, 0, 0, 0, 0, STAT_REJECTED);
    // Register above the maximum clamps: full-width strip lands on the skyline.
    plan(DIM_MAX, MAX_SIDE, 1, 1, 0, 1, 4, 0);
    plan(KEEP_SIDE, MAX_SIDE - 1, 3);
    plan(KEEP_SIDE, 1, MAX_SIDE - 2);          // rightmost column, up to the top
    // Side shrunk mid-atlas: columns kept, tall ones skipped.
    plan(16, 4, 11);
    plan(KEEP_SIDE, 4, 11);
    plan(12, 4, 7);
    plan(KEEP_SIDE, 1, 1);                     // nothing below 12 left: new atlas
    plan(KEEP_SIDE, 2, 2);                     // leftmost of the equal windows
    plan(MAX_SIDE, 1, MAX_SIDE);
    plan(KEEP_SIDE, MAX_SIDE, 1);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      // register writes only with nothing in flight
      if (probes[i].side != KEEP_SIDE) begin
        drain();
        write_side(probes[i].side);
      end
      offer_word(probes[i].w, probes[i].h, probes[i].typed, probes[i].want);
      source_gap();
    end

    // Random phases; each starts idle, with a new side.
    foreach (phase_side[p]) begin
      drain();
      write_side(phase_side[p]);
      idle_on = (p % 4) != 2;   // a couple of phases run back to back
      if (p == 0)
        hold_off_req = 1'b1;    // sink stalls long while words keep coming
      repeat (phase_len[p]) begin
        pick_rect(w, h);
        offer_word(w, h, 1'b0, none);
        source_gap();
      end
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
